// ===== sv/pva_pkg.sv =====
// Package for the polyphonic voice allocator: request/result types, config
// struct, command and register codes, and small helper functions.
// No dependencies.
`default_nettype none
package pva_pkg;

    localparam int DEF_VOICES = 6;
    localparam int DEF_NOTES  = 128;
    localparam int MAX_EV     = 6;
    localparam int CFG_AW     = 6;

    localparam logic [2:0] CMD_NOTE       = 3'd0;
    localparam logic [2:0] CMD_VOICE_DONE = 3'd1;
    localparam logic [2:0] CMD_ALL_DONE   = 3'd2;
    localparam logic [2:0] CMD_KEYS_OFF   = 3'd3;
    localparam logic [2:0] CMD_HOLD       = 3'd4;

    localparam logic [1:0] PRI_LAST = 2'd0;
    localparam logic [1:0] PRI_LOW  = 2'd1;
    localparam logic [1:0] PRI_HIGH = 2'd2;

    localparam logic [2:0] REG_PRIORITY = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_OLDEST   = 3'd2;
    localparam logic [2:0] REG_UNISON   = 3'd3;
    localparam logic [2:0] REG_PATTERN  = 3'd4;

    localparam logic [7:0]  NO_NOTE     = 8'hFF;
    localparam logic [7:0]  PAT_END     = 8'hFF;
    localparam logic [5:0]  MASK_RST    = 6'h3F;
    localparam logic [47:0] PATTERN_RST = 48'hFFFF_FFFF_FF00;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  note;
        logic        gate;
        logic [15:0] velocity;
        logic        from_keyboard;
        logic [2:0]  voice_index;
        logic        hold_on;
        logic [31:0] timestamp;
    } t_req;

    typedef struct packed {
        logic        event_valid;
        logic [7:0]  event_note;
        logic        event_gate;
        logic [2:0]  event_voice;
        logic [15:0] event_velocity;
        logic        legato;
        logic        last;
        logic        any_pressed;
        logic        any_assigned;
    } t_res;

    typedef struct packed {
        logic [1:0]  priority_cfg;
        logic [5:0]  voice_mask;
        logic        oldest_free_mode;
        logic        unison_mode;
        logic [47:0] chord_pattern;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  note;
        logic        gate;
        logic [2:0]  voice;
        logic [15:0] vel;
        logic        leg;
    } t_evt;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_qitem;

    function automatic logic voice_en(input logic [5:0] mask, input logic [2:0] v);
        logic [7:0] m;
        m = {2'b00, mask};
        return m[v];
    endfunction

    function automatic logic [1:0] eff_prio(input logic [1:0] p);
        return (p > PRI_HIGH) ? PRI_LAST : p;
    endfunction

endpackage
`default_nettype wire

// ===== sv/poly_voice_allocator_core.sv =====
// Top level of the polyphonic voice allocator: APB register file, request
// queue front end, sequencer back end and key velocity RAM.
// Depends on pva_pkg, pva_ram, pva_front and pva_back.
//
// Usage: a request is taken when start is high and busy is low; busy rises
// only when the two-entry request queue is full. Each request yields one to
// six results, one per cycle on o_result with o_strobe high for that cycle;
// the final one has last set. A request with no voice event gives one result
// with event_valid low. Results cannot be held off by the receiver.
// A key release scans every key, one per cycle, and may scan the keys again
// when a held key gets its voice back in unison mode; a press without unison
// walks the voice table up to three times, then assigns the chord slots, then
// sends the results. Registers are written over APB (64-bit data, register i
// at byte 8*i); the user must write them only while the block is idle, as the
// block itself does not enforce this. Reset clears key map, voices, hold and
// registers; the velocity RAM is not cleared.
`default_nettype none
module poly_voice_allocator_core #(
    parameter int VOICES = pva_pkg::DEF_VOICES,
    parameter int NOTES  = pva_pkg::DEF_NOTES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire pva_pkg::t_req              i_request,
    output logic                            o_strobe,
    output pva_pkg::t_res                   o_result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pva_pkg::CFG_AW-1:0] paddr,
    input  wire logic [63:0]                pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);
    pva_pkg::t_cfg               r_cfg;
    pva_pkg::t_qitem             q;
    logic                        pop;
    logic                        ram_we;
    logic [$clog2(NOTES)-1:0]    ram_waddr;
    logic [$clog2(NOTES)-1:0]    ram_raddr;
    logic [15:0]                 ram_wdata;
    logic [15:0]                 ram_rdata;
    logic [2:0]                  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pva_pkg::CFG_AW-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.priority_cfg     <= pva_pkg::PRI_LAST;
            r_cfg.voice_mask       <= pva_pkg::MASK_RST;
            r_cfg.oldest_free_mode <= 1'b0;
            r_cfg.unison_mode      <= 1'b0;
            r_cfg.chord_pattern    <= pva_pkg::PATTERN_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                pva_pkg::REG_PRIORITY: r_cfg.priority_cfg     <= pwdata[1:0];
                pva_pkg::REG_MASK:     r_cfg.voice_mask       <= pwdata[5:0];
                pva_pkg::REG_OLDEST:   r_cfg.oldest_free_mode <= pwdata[0];
                pva_pkg::REG_UNISON:   r_cfg.unison_mode      <= pwdata[0];
                pva_pkg::REG_PATTERN:  r_cfg.chord_pattern    <= pwdata[47:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pva_pkg::REG_PRIORITY: prdata = 64'(r_cfg.priority_cfg);
            pva_pkg::REG_MASK:     prdata = 64'(r_cfg.voice_mask);
            pva_pkg::REG_OLDEST:   prdata = 64'(r_cfg.oldest_free_mode);
            pva_pkg::REG_UNISON:   prdata = 64'(r_cfg.unison_mode);
            pva_pkg::REG_PATTERN:  prdata = 64'(r_cfg.chord_pattern);
            default:               prdata = 64'd0;
        endcase
    end

    pva_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_request),
        .o_busy  (busy),
        .i_pop   (pop),
        .o_q     (q)
    );

    pva_ram #(
        .WIDTH (16),
        .DEPTH (NOTES)
    ) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pva_back #(
        .VOICES (VOICES),
        .NOTES  (NOTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q         (q),
        .o_pop       (pop),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_strobe)
        else $error("result strobe continued past last");

    a_null_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.event_valid |-> o_result.last)
        else $error("empty result not marked last");

    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.event_valid |-> 4'(o_result.event_voice) < 4'(VOICES))
        else $error("event addresses a nonexistent voice");

endmodule
`default_nettype wire

// ===== sv/pva_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/pva_front.sv =====
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on pva_pkg.
`default_nettype none
module pva_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire pva_pkg::t_req i_req,
    output logic               o_busy,
    input  wire logic          i_pop,
    output pva_pkg::t_qitem    o_q
);
    pva_pkg::t_req r_m [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;

    assign o_busy    = (r_cnt == 2'd2);
    assign push      = i_start && !o_busy;
    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.req   = r_m[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_m[r_wp] <= i_req;
                r_wp      <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/pva_back.sv =====
// Back end: sequencer that executes one request at a time, keeps the
// key map and voice table, buffers events and streams results. Uses pva_pkg.
`default_nettype none
module pva_back #(
    parameter int VOICES = pva_pkg::DEF_VOICES,
    parameter int NOTES  = pva_pkg::DEF_NOTES
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire pva_pkg::t_cfg            i_cfg,
    input  wire pva_pkg::t_qitem          i_q,
    output logic                          o_pop,
    output logic                          o_ram_we,
    output logic [$clog2(NOTES)-1:0]      o_ram_waddr,
    output logic [15:0]                   o_ram_wdata,
    output logic [$clog2(NOTES)-1:0]      o_ram_raddr,
    input  wire logic [15:0]              i_ram_rdata,
    output logic                          o_strobe,
    output pva_pkg::t_res                 o_result
);
    localparam int KIW = $clog2(NOTES);
    localparam int VIW = $clog2(VOICES);
    localparam int VCW = $clog2(VOICES + 1);
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_START = 10'b0000000010,
        S_BEGIN = 10'b0000000100,
        S_UNI   = 10'b0000001000,
        S_SEL   = 10'b0000010000,
        S_RDV   = 10'b0000100000,
        S_ASN   = 10'b0001000000,
        S_OFF   = 10'b0010000000,
        S_VLP   = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } t_state;

    t_state            r_state;
    pva_pkg::t_req     r_req;
    logic [NOTES-1:0]  r_key;
    logic [VOICES-1:0] r_asg;
    logic [VOICES-1:0] r_gat;
    logic [VOICES-1:0] r_prs;
    logic [15:0]       r_vvel  [VOICES];
    logic [7:0]        r_root  [VOICES];
    logic [7:0]        r_vnote [VOICES];
    logic [31:0]       r_stamp [VOICES];
    logic              r_hold;
    logic [KIW-1:0]    r_kcnt;
    logic [VCW-1:0]    r_vcnt;
    logic [1:0]        r_phase;
    logic              r_ok;
    logic [VIW-1:0]    r_pick;
    logic [31:0]       r_best;
    logic [7:0]        r_cmp;
    logic [6:0]        r_rn;
    logic [15:0]       r_avel;
    logic              r_leg;
    logic [2:0]        r_slot;
    logic [VIW-1:0]    r_v;
    pva_pkg::t_evt     r_ev [pva_pkg::MAX_EV];
    logic [2:0]        r_evn;
    logic [2:0]        r_eidx;
    logic              r_stb;
    pva_pkg::t_res     r_out;

    logic [1:0]     prio;
    logic [VIW-1:0] cv;
    logic           cv_en;
    logic [7:0]     cv_root;
    logic           cv_down;
    logic           nxt_ok;
    logic [VIW-1:0] nxt_v;
    logic [KIW-1:0] rst_idx;
    logic           rooted;
    logic [7:0]     b0;
    logic [7:0]     bi;
    logic           pat_end;
    logic [7:0]     offs;
    logic           note_ok;
    logic [KIW-1:0] note_idx;
    logic [KIW-1:0] rn_idx;
    logic           ev_room;

    always_comb begin
        int c;
        prio     = pva_pkg::eff_prio(i_cfg.priority_cfg);
        cv       = r_vcnt[VIW-1:0];
        cv_en    = pva_pkg::voice_en(i_cfg.voice_mask, 3'(cv));
        cv_root  = r_root[cv];
        cv_down  = r_asg[cv] && (cv_root < 8'(NOTES)) && r_key[cv_root[KIW-1:0]];
        nxt_ok   = 1'b0;
        nxt_v    = '0;
        for (int k = 1; k <= VOICES; k++) begin
            c = int'(r_v) + k;
            if (c >= VOICES) begin
                c = c - VOICES;
            end
            if (!nxt_ok && pva_pkg::voice_en(i_cfg.voice_mask, 3'(c))) begin
                nxt_ok = 1'b1;
                nxt_v  = VIW'(c);
            end
        end
        rst_idx  = (prio == pva_pkg::PRI_HIGH) ? (KIW'(NOTES - 1) - r_kcnt) : r_kcnt;
        rooted   = 1'b0;
        for (int v = 0; v < VOICES; v++) begin
            if (r_asg[v] && r_root[v] == 8'(rst_idx)) begin
                rooted = 1'b1;
            end
        end
        b0       = i_cfg.chord_pattern[7:0];
        bi       = 8'(i_cfg.chord_pattern >> {r_slot, 3'b000});
        pat_end  = (r_slot >= 3'd6) || (4'(r_slot) >= 4'(VOICES))
                || (b0 != pva_pkg::PAT_END && r_slot != 3'd0 && bi == pva_pkg::PAT_END);
        offs     = (b0 == pva_pkg::PAT_END || r_slot == 3'd0) ? 8'd0 : bi;
        note_ok  = 8'(r_req.note) < 8'(NOTES);
        note_idx = r_req.note[KIW-1:0];
        rn_idx   = r_rn[KIW-1:0];
        ev_room  = r_evn < 3'(pva_pkg::MAX_EV);
    end

    assign o_pop       = (r_state == S_IDLE) && i_q.valid;
    assign o_ram_we    = (r_state == S_START) && (r_req.command == pva_pkg::CMD_NOTE)
                       && note_ok && r_req.gate;
    assign o_ram_waddr = note_idx;
    assign o_ram_wdata = r_req.velocity;
    assign o_ram_raddr = rst_idx;
    assign o_strobe    = r_stb;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key   <= '0;
            r_asg   <= '0;
            r_gat   <= '0;
            r_prs   <= '0;
            r_hold  <= 1'b0;
            r_stb   <= 1'b0;
            r_evn   <= 3'd0;
            r_eidx  <= 3'd0;
            for (int v = 0; v < VOICES; v++) begin
                r_vvel[v]  <= 16'd0;
                r_root[v]  <= pva_pkg::NO_NOTE;
                r_vnote[v] <= pva_pkg::NO_NOTE;
                r_stamp[v] <= 32'd0;
            end
        end else begin
            r_stb <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        r_req   <= i_q.req;
                        r_evn   <= 3'd0;
                        r_eidx  <= 3'd0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_kcnt  <= '0;
                    r_vcnt  <= '0;
                    r_state <= S_EMIT;
                    case (r_req.command)
                        pva_pkg::CMD_NOTE: begin
                            if (note_ok) begin
                                r_key[note_idx] <= r_req.gate;
                                r_rn            <= r_req.note;
                                r_avel          <= r_req.velocity;
                                r_leg           <= 1'b0;
                                r_state         <= r_req.gate ? S_BEGIN : S_OFF;
                            end
                        end
                        pva_pkg::CMD_VOICE_DONE: begin
                            if (4'(r_req.voice_index) < 4'(VOICES)) begin
                                r_asg[VIW'(r_req.voice_index)]   <= 1'b0;
                                r_prs[VIW'(r_req.voice_index)]   <= 1'b0;
                                r_root[VIW'(r_req.voice_index)]  <= pva_pkg::NO_NOTE;
                                r_vnote[VIW'(r_req.voice_index)] <= pva_pkg::NO_NOTE;
                            end
                        end
                        pva_pkg::CMD_ALL_DONE: begin
                            r_asg <= '0;
                            r_prs <= '0;
                            r_key <= '0;
                            for (int v = 0; v < VOICES; v++) begin
                                r_root[v]  <= pva_pkg::NO_NOTE;
                                r_vnote[v] <= pva_pkg::NO_NOTE;
                                r_stamp[v] <= 32'd0;
                            end
                        end
                        pva_pkg::CMD_KEYS_OFF: begin
                            r_state <= S_VLP;
                        end
                        pva_pkg::CMD_HOLD: begin
                            r_hold <= r_req.hold_on;
                            if (!r_req.hold_on) begin
                                r_state <= S_VLP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_BEGIN: begin
                    r_kcnt  <= '0;
                    r_vcnt  <= '0;
                    r_slot  <= 3'd0;
                    r_ok    <= 1'b0;
                    r_phase <= PH_A;
                    if (i_cfg.unison_mode) begin
                        r_v     <= '0;
                        r_state <= (prio != pva_pkg::PRI_LAST) ? S_UNI : S_ASN;
                    end else begin
                        r_state <= S_SEL;
                    end
                end
                S_UNI: begin
                    if (r_kcnt != rn_idx && r_key[r_kcnt]) begin
                        r_leg <= 1'b1;
                    end
                    if (r_kcnt != rn_idx && r_key[r_kcnt]
                        && ((rn_idx > r_kcnt && prio == pva_pkg::PRI_LOW)
                         || (rn_idx < r_kcnt && prio == pva_pkg::PRI_HIGH))) begin
                        r_state <= S_EMIT;
                    end else if (r_kcnt == KIW'(NOTES - 1)) begin
                        r_state <= S_ASN;
                    end else begin
                        r_kcnt <= r_kcnt + 1'b1;
                    end
                end
                S_SEL: begin
                    if (r_vcnt == VCW'(VOICES)) begin
                        r_vcnt <= '0;
                        r_ok   <= 1'b0;
                        r_cmp  <= {1'b0, r_rn};
                        if (r_ok) begin
                            r_v     <= r_pick;
                            r_state <= S_ASN;
                        end else if (r_phase == PH_C) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_phase <= r_phase + 2'd1;
                        end
                    end else begin
                        r_vcnt <= r_vcnt + 1'b1;
                        if (cv_en) begin
                            case (r_phase)
                                PH_A: begin
                                    if (r_asg[cv]) begin
                                        if (r_stamp[cv] < r_req.timestamp
                                            && r_vnote[cv] == {1'b0, r_rn}) begin
                                            r_v     <= cv;
                                            r_state <= S_ASN;
                                        end
                                    end else if (!i_cfg.oldest_free_mode) begin
                                        if (!r_ok) begin
                                            r_ok   <= 1'b1;
                                            r_pick <= cv;
                                        end
                                    end else if (!r_ok || r_stamp[cv] < r_best) begin
                                        r_ok   <= 1'b1;
                                        r_pick <= cv;
                                        r_best <= r_stamp[cv];
                                    end
                                end
                                PH_B: begin
                                    if (!cv_down && (!r_ok || r_stamp[cv] < r_best)) begin
                                        r_ok   <= 1'b1;
                                        r_pick <= cv;
                                        r_best <= r_stamp[cv];
                                    end
                                end
                                default: begin
                                    if (prio == pva_pkg::PRI_LOW) begin
                                        if (r_vnote[cv] > r_cmp) begin
                                            r_ok   <= 1'b1;
                                            r_pick <= cv;
                                            r_cmp  <= r_vnote[cv];
                                        end
                                    end else if (prio == pva_pkg::PRI_HIGH) begin
                                        if (r_vnote[cv] < r_cmp) begin
                                            r_ok   <= 1'b1;
                                            r_pick <= cv;
                                            r_cmp  <= r_vnote[cv];
                                        end
                                    end else if (!r_ok || r_stamp[cv] < r_best) begin
                                        r_ok   <= 1'b1;
                                        r_pick <= cv;
                                        r_best <= r_stamp[cv];
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_OFF: begin
                    if (r_key[rst_idx] && !rooted) begin
                        r_rn    <= 7'(rst_idx);
                        r_state <= S_RDV;
                    end else if (r_kcnt == KIW'(NOTES - 1)) begin
                        r_vcnt  <= '0;
                        r_state <= S_VLP;
                    end else begin
                        r_kcnt <= r_kcnt + 1'b1;
                    end
                end
                S_RDV: begin
                    r_avel  <= i_ram_rdata;
                    r_leg   <= 1'b1;
                    r_state <= S_BEGIN;
                end
                S_ASN: begin
                    if (pat_end) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_asg[r_v]   <= 1'b1;
                        r_gat[r_v]   <= 1'b1;
                        r_prs[r_v]   <= 1'b1;
                        r_vvel[r_v]  <= r_avel;
                        r_root[r_v]  <= {1'b0, r_rn};
                        r_vnote[r_v] <= {1'b0, r_rn} + offs;
                        r_stamp[r_v] <= r_req.timestamp;
                        if (ev_room) begin
                            r_ev[r_evn] <= '{note: {1'b0, r_rn} + offs, gate: 1'b1,
                                             voice: 3'(r_v), vel: r_avel, leg: r_leg};
                            r_evn       <= r_evn + 3'd1;
                        end
                        r_slot <= r_slot + 3'd1;
                        if (nxt_ok) begin
                            r_v <= nxt_v;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_VLP: begin
                    case (r_req.command)
                        pva_pkg::CMD_NOTE: begin
                            if (r_asg[cv] && r_root[cv] == {1'b0, r_req.note}) begin
                                r_prs[cv] <= 1'b0;
                                if (!r_hold || i_cfg.unison_mode) begin
                                    r_gat[cv] <= 1'b0;
                                    if (ev_room) begin
                                        r_ev[r_evn] <= '{note: r_vnote[cv], gate: 1'b0,
                                                         voice: 3'(cv),
                                                         vel: r_req.velocity, leg: 1'b0};
                                        r_evn       <= r_evn + 3'd1;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (cv_en && r_gat[cv] && (r_req.command == pva_pkg::CMD_KEYS_OFF
                                                       || !r_prs[cv])) begin
                                r_gat[cv] <= 1'b0;
                                if (r_req.command == pva_pkg::CMD_KEYS_OFF) begin
                                    r_prs[cv] <= 1'b0;
                                end
                                if (ev_room) begin
                                    r_ev[r_evn] <= '{note: r_vnote[cv], gate: 1'b0,
                                                     voice: 3'(cv), vel: r_vvel[cv],
                                                     leg: 1'b0};
                                    r_evn       <= r_evn + 3'd1;
                                end
                            end
                        end
                    endcase
                    if (r_vcnt == VCW'(VOICES - 1)) begin
                        if (r_req.command == pva_pkg::CMD_KEYS_OFF) begin
                            r_key  <= '0;
                            r_hold <= 1'b0;
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_vcnt <= r_vcnt + 1'b1;
                    end
                end
                S_EMIT: begin
                    r_stb              <= 1'b1;
                    r_out.any_pressed  <= |r_key;
                    r_out.any_assigned <= |r_asg;
                    if (r_evn == 3'd0) begin
                        r_out.event_valid    <= 1'b0;
                        r_out.event_note     <= 8'd0;
                        r_out.event_gate     <= 1'b0;
                        r_out.event_voice    <= 3'd0;
                        r_out.event_velocity <= 16'd0;
                        r_out.legato         <= 1'b0;
                        r_out.last           <= 1'b1;
                        r_state              <= S_IDLE;
                    end else begin
                        r_out.event_valid    <= 1'b1;
                        r_out.event_note     <= r_ev[r_eidx].note;
                        r_out.event_gate     <= r_ev[r_eidx].gate;
                        r_out.event_voice    <= r_ev[r_eidx].voice;
                        r_out.event_velocity <= r_ev[r_eidx].vel;
                        r_out.legato         <= r_ev[r_eidx].leg;
                        r_out.last           <= (r_eidx == r_evn - 3'd1);
                        if (r_eidx == r_evn - 3'd1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_eidx <= r_eidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
